/* hdl/assert_macros.svh */
// Assertion macros shared by the depth grid triangulator modules.
// Each macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/dgt_pkg.sv */
// Shared types, constants and the depth-to-z table of the depth grid triangulator.
// No dependencies; imported by the front, queue, back and top level modules.
`timescale 1ns / 1ps

package dgt_pkg;

   // default sizes and fixed field widths
   localparam int DEF_MAX_WIDTH = 1024;
   localparam int DEF_MAX_PITCH = 64;
   localparam int MAX_HEIGHT    = 1024;
   localparam int ALPHA_W       = 8;
   localparam int DIM_W         = 11;
   localparam int PITCH_REG_W   = 7;
   localparam int ROW_W         = 10;
   localparam int X2_W          = 11;
   localparam int Z_W           = 18;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 11;
   localparam int QUEUE_DEPTH   = 2;
   localparam int MIN_DIM       = 2;
   localparam int MIN_PITCH     = 1;

   // register values after reset
   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;
   localparam int RESET_PITCH  = 5;

   // depth mapping: z = round(alpha * Z_SCALE / Z_DIV) - Z_OFFSET
   localparam int Z_SCALE   = 245760;
   localparam int Z_DIV     = 255;
   localparam int Z_ROUND   = 127;
   localparam int Z_OFFSET  = 122880;
   localparam int Z_ENTRIES = 256;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_GRID_PITCH   = 2'd2
   } csr_index_type;

   // order of the six vertices of a quad: nw,ne,se then nw,se,sw
   typedef enum logic [2:0] {
      SLOT_NW0 = 3'd0,
      SLOT_NE  = 3'd1,
      SLOT_SE0 = 3'd2,
      SLOT_NW1 = 3'd3,
      SLOT_SE1 = 3'd4,
      SLOT_SW  = 3'd5
   } vert_slot_type;

   typedef logic [Z_W-1:0] z_table_type [Z_ENTRIES];

   // build the alpha to fixed point z table at elaboration
   function automatic z_table_type build_z_table();
      z_table_type tab;
      int          i;
      int          q;
      for (i = 0; i < Z_ENTRIES; i++) begin
         q      = (i * Z_SCALE + Z_ROUND) / Z_DIV;
         tab[i] = Z_W'(q - Z_OFFSET);
      end
      return tab;
   endfunction

   localparam z_table_type Z_TABLE = build_z_table();

endpackage

/* hdl/dgt_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies; used for the grid row line buffer.
`timescale 1ns / 1ps

module dgt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/dgt_front.sv */
// Front end: accepts pixels, tracks raster and grid position, reads the line buffer
// and forms quads with four nonzero corners. Depends on dgt_pkg, dgt_ram, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dgt_front
   import dgt_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAX_PITCH = DEF_MAX_PITCH
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_ready,
   input  logic [ALPHA_W-1:0]                         req_alpha,
   input  logic                                       req_frame_start,
   input  logic [DIM_W-1:0]                           cfg_width,
   input  logic [DIM_W-1:0]                           cfg_height,
   input  logic [$clog2(MAX_PITCH+1)-1:0]             cfg_pitch,
   output logic                                       quad_valid,
   input  logic                                       quad_ready,
   output logic [2*$clog2(MAX_WIDTH)+2*ROW_W+4*ALPHA_W-1:0] quad_data
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int PW = (MAX_PITCH > 1) ? $clog2(MAX_PITCH) : 1;

   // position state
   logic [CW-1:0]      col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [PW-1:0]      cph_ff, cph_in;
   logic [PW-1:0]      rph_ff, rph_in;

   // second stage
   logic               b_valid_ff;
   logic               b_grid_ff;
   logic               b_pos_ff;
   logic [CW-1:0]      b_col_ff;
   logic [ROW_W-1:0]   b_row_ff;
   logic [ALPHA_W-1:0] b_alpha_ff;
   logic               b_fwd_ff;
   logic [ALPHA_W-1:0] b_fwd_data_ff;

   logic [ALPHA_W-1:0] left_cur_ff;
   logic [ALPHA_W-1:0] left_above_ff;

   logic [CW-1:0]      c_eff;
   logic [ROW_W-1:0]   r_eff;
   logic [PW-1:0]      cph_eff;
   logic [PW-1:0]      rph_eff;
   logic               grid;
   logic               pos_ok;
   logic               fwd_in;
   logic               req_fire;
   logic               b_emit;
   logic               b_fire;
   logic [ALPHA_W-1:0] above;
   logic [ALPHA_W-1:0] ram_rd_data;
   logic [CW-1:0]      x_west;
   logic [ROW_W-1:0]   y_north;

   // frame start puts this pixel at the origin
   always_comb begin
      c_eff   = req_frame_start ? '0 : col_ff;
      r_eff   = req_frame_start ? '0 : row_ff;
      cph_eff = req_frame_start ? '0 : cph_ff;
      rph_eff = req_frame_start ? '0 : rph_ff;
      grid    = (cph_eff == '0) && (rph_eff == '0);
      pos_ok  = (32'(c_eff) >= 32'(cfg_pitch)) && (32'(r_eff) >= 32'(cfg_pitch));
   end

   // advance column, row and grid phases
   always_comb begin
      col_in = c_eff;
      row_in = r_eff;
      cph_in = cph_eff;
      rph_in = rph_eff;
      if (32'(c_eff) + 32'd1 >= 32'(cfg_width)) begin
         col_in = '0;
         cph_in = '0;
         if (32'(r_eff) + 32'd1 >= 32'(cfg_height)) begin
            row_in = '0;
            rph_in = '0;
         end else begin
            row_in = r_eff + ROW_W'(1);
            rph_in = (32'(rph_eff) + 32'd1 >= 32'(cfg_pitch)) ? '0 : rph_eff + PW'(1);
         end
      end else begin
         col_in = c_eff + CW'(1);
         cph_in = (32'(cph_eff) + 32'd1 >= 32'(cfg_pitch)) ? '0 : cph_eff + PW'(1);
      end
   end

   // second stage handshake: stall only on a quad the queue cannot take
   assign above     = b_fwd_ff ? b_fwd_data_ff : ram_rd_data;
   assign b_emit    = b_grid_ff && b_pos_ff && (b_alpha_ff != '0) && (above != '0)
                      && (left_cur_ff != '0) && (left_above_ff != '0);
   assign b_fire    = b_valid_ff && (!b_emit || quad_ready);
   assign req_ready = !b_valid_ff || b_fire;
   assign req_fire  = req_valid && req_ready;

   // forward the entry the second stage writes in the cycle it is read
   assign fwd_in = b_valid_ff && b_grid_ff && (b_col_ff == c_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         cph_ff <= '0;
         rph_ff <= '0;
      end else if (req_fire) begin
         col_ff <= col_in;
         row_ff <= row_in;
         cph_ff <= cph_in;
         rph_ff <= rph_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (req_fire) begin
         b_valid_ff <= 1'b1;
      end else if (b_fire) begin
         b_valid_ff <= 1'b0;
      end
   end

   // hold the item for the second stage
   always_ff @(posedge clock) begin
      if (req_fire) begin
         b_grid_ff     <= grid;
         b_pos_ff      <= pos_ok;
         b_col_ff      <= c_eff;
         b_row_ff      <= r_eff;
         b_alpha_ff    <= req_alpha;
         b_fwd_ff      <= fwd_in;
         b_fwd_data_ff <= b_alpha_ff;
      end
   end

   // keep the west corners of the next quad
   always_ff @(posedge clock) begin
      if (reset) begin
         left_cur_ff   <= '0;
         left_above_ff <= '0;
      end else if (b_fire && b_grid_ff) begin
         left_cur_ff   <= b_alpha_ff;
         left_above_ff <= above;
      end
   end

   // line buffer of the previous grid row
   dgt_ram #(
      .WIDTH (ALPHA_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (b_fire && b_grid_ff),
      .wr_addr (b_col_ff),
      .wr_data (b_alpha_ff),
      .rd_en   (req_fire && grid),
      .rd_addr (c_eff),
      .rd_data (ram_rd_data)
   );

   // pack the quad: positions then nw, ne, se, sw depths
   assign x_west     = b_col_ff - CW'(cfg_pitch);
   assign y_north    = b_row_ff - ROW_W'(cfg_pitch);
   assign quad_valid = b_valid_ff && b_emit;
   assign quad_data  = {x_west, b_col_ff, y_north, b_row_ff,
                        left_above_ff, above, b_alpha_ff, left_cur_ff};

   `ASSERT_ALWAYS(a_no_accept_on_stall, !(req_fire && b_valid_ff && !b_fire),
      "front accepted an item while the second stage was stalled")

endmodule

/* hdl/dgt_queue.sv */
// Small FIFO that decouples quad forming from vertex output.
// Depends on dgt_pkg for its default depth and on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dgt_queue
   import dgt_pkg::*;
#(
   parameter int DATA_W = 64,
   parameter int DEPTH  = QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] data_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push_en;
   logic              pop_en;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push_en    = push_valid && push_ready;
   assign pop_en     = pop_valid && pop_ready;
   assign pop_data   = data_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push_en && !pop_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_en && !push_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push_en) begin
            wr_ptr_ff <= (32'(wr_ptr_ff) == DEPTH - 1) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop_en) begin
            rd_ptr_ff <= (32'(rd_ptr_ff) == DEPTH - 1) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   // store entries
   always_ff @(posedge clock) begin
      if (push_en) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_ALWAYS(a_count_bound, 32'(count_ff) <= DEPTH,
      "queue fill count beyond its depth")
   `ASSERT_NEXT(a_push_counts, push_en && !pop_en, count_ff != '0,
      "queue empty right after a push")

endmodule

/* hdl/dgt_back.sv */
// Back end: walks each quad through its six vertices and drives the vertex output register.
// Depends on dgt_pkg (slot order, z table) and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dgt_back
   import dgt_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            quad_valid,
   output logic                                            quad_pop,
   input  logic [2*$clog2(MAX_WIDTH)+2*ROW_W+4*ALPHA_W-1:0] quad_data,
   input  logic [DIM_W-1:0]                                cfg_width,
   input  logic [DIM_W-1:0]                                cfg_height,
   output logic                                            rsp_valid,
   input  logic                                            rsp_ready,
   output logic signed [X2_W-1:0]                          rsp_vert_x2,
   output logic signed [X2_W-1:0]                          rsp_vert_y2,
   output logic signed [Z_W-1:0]                           rsp_vert_z,
   output logic                                            rsp_last
);

   localparam int CW = $clog2(MAX_WIDTH);

   logic [CW-1:0]      x_west, x_east;
   logic [ROW_W-1:0]   y_north, y_south;
   logic [ALPHA_W-1:0] a_nw, a_ne, a_se, a_sw;

   vert_slot_type      slot_ff, slot_in;
   logic               rsp_valid_ff;
   logic [X2_W-1:0]    x2_ff, x2_in;
   logic [X2_W-1:0]    y2_ff, y2_in;
   logic [Z_W-1:0]     z_ff, z_in;
   logic               last_ff;
   logic               load;
   logic [CW-1:0]      x_sel;
   logic [ROW_W-1:0]   y_sel;
   logic [ALPHA_W-1:0] a_sel;

   assign {x_west, x_east, y_north, y_south, a_nw, a_ne, a_se, a_sw} = quad_data;

   // fill the output register whenever a quad is waiting and the register is empty or being taken
   assign load     = quad_valid && (!rsp_valid_ff || rsp_ready);
   assign quad_pop = load && (slot_ff == SLOT_SW);

   // pick the corner of this slot and step to the next
   always_comb begin
      x_sel   = x_west;
      y_sel   = y_north;
      a_sel   = a_nw;
      slot_in = slot_ff;
      unique case (slot_ff)
         SLOT_NW0: begin
            slot_in = SLOT_NE;
         end
         SLOT_NE: begin
            x_sel   = x_east;
            a_sel   = a_ne;
            slot_in = SLOT_SE0;
         end
         SLOT_SE0: begin
            x_sel   = x_east;
            y_sel   = y_south;
            a_sel   = a_se;
            slot_in = SLOT_NW1;
         end
         SLOT_NW1: begin
            slot_in = SLOT_SE1;
         end
         SLOT_SE1: begin
            x_sel   = x_east;
            y_sel   = y_south;
            a_sel   = a_se;
            slot_in = SLOT_SW;
         end
         SLOT_SW: begin
            y_sel   = y_south;
            a_sel   = a_sw;
            slot_in = SLOT_NW0;
         end
         default: begin
            slot_in = SLOT_NW0;
         end
      endcase
   end

   // centre the position in half pixels and map depth
   assign x2_in = X2_W'(32'd2 * 32'(x_sel) - 32'(cfg_width));
   assign y2_in = X2_W'(32'd2 * 32'(y_sel) - 32'(cfg_height));
   assign z_in  = Z_TABLE[a_sel];

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= SLOT_NW0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            slot_ff      <= slot_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // hold the vertex until taken
   always_ff @(posedge clock) begin
      if (load) begin
         x2_ff   <= x2_in;
         y2_ff   <= y2_in;
         z_ff    <= z_in;
         last_ff <= (slot_ff == SLOT_SW);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_vert_x2 = signed'(x2_ff);
   assign rsp_vert_y2 = signed'(y2_ff);
   assign rsp_vert_z  = signed'(z_ff);
   assign rsp_last    = last_ff;

   `ASSERT_NEXT(a_last_restarts, load && (slot_ff == SLOT_SW),
      slot_ff == SLOT_NW0 && rsp_valid_ff && last_ff,
      "closing vertex did not restart the slot sequence")

endmodule

/* hdl/depth_grid_triangulator_top.sv */
// Depth grid triangulator: pixels in raster order in, triangle vertices out.
// A closing pixel passes the front second stage register, the quad queue and the vertex
// output register before its quad's first vertex is valid. Throughput: one pixel a cycle
// while the 2-entry quad queue has room; each quad's six vertices share one output register.
// Reset clears counters, west corners, queue and output; registers return to 640, 480, 5;
// the line buffer RAM is not cleared. Depends on dgt_pkg, dgt_front, dgt_queue, dgt_back.
`timescale 1ns / 1ps

module depth_grid_triangulator_top
   import dgt_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAX_PITCH = DEF_MAX_PITCH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ALPHA_W-1:0]            req_alpha,
   input  logic                          req_frame_start,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [X2_W-1:0]        rsp_vert_x2,
   output logic signed [X2_W-1:0]        rsp_vert_y2,
   output logic signed [Z_W-1:0]         rsp_vert_z,
   output logic                          rsp_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata
);

   localparam int PVW    = $clog2(MAX_PITCH + 1);
   localparam int QUAD_W = 2 * $clog2(MAX_WIDTH) + 2 * ROW_W + 4 * ALPHA_W;
   localparam int RST_W  = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
   localparam int RST_P  = (RESET_PITCH > MAX_PITCH) ? MAX_PITCH : RESET_PITCH;

   logic [DIM_W-1:0]  width_ff, width_in;
   logic [DIM_W-1:0]  height_ff, height_in;
   logic [PVW-1:0]    pitch_ff, pitch_in;
   logic              csr_fire;
   logic [PITCH_REG_W-1:0] pitch_raw;

   logic              fq_valid, fq_ready;
   logic [QUAD_W-1:0] fq_data;
   logic              qb_valid, qb_pop;
   logic [QUAD_W-1:0] qb_data;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign pitch_raw = csr_wdata[PITCH_REG_W-1:0];

   // saturate the written register into its range; the pitch uses only the low PITCH_REG_W data bits
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      pitch_in  = pitch_ff;
      unique case (csr_index)
         CSR_IMAGE_WIDTH: begin
            if (32'(csr_wdata) < MIN_DIM) begin
               width_in = DIM_W'(MIN_DIM);
            end else if (32'(csr_wdata) > MAX_WIDTH) begin
               width_in = DIM_W'(MAX_WIDTH);
            end else begin
               width_in = csr_wdata;
            end
         end
         CSR_IMAGE_HEIGHT: begin
            if (32'(csr_wdata) < MIN_DIM) begin
               height_in = DIM_W'(MIN_DIM);
            end else if (32'(csr_wdata) > MAX_HEIGHT) begin
               height_in = DIM_W'(MAX_HEIGHT);
            end else begin
               height_in = csr_wdata;
            end
         end
         CSR_GRID_PITCH: begin
            if (32'(pitch_raw) < MIN_PITCH) begin
               pitch_in = PVW'(MIN_PITCH);
            end else if (32'(pitch_raw) > MAX_PITCH) begin
               pitch_in = PVW'(MAX_PITCH);
            end else begin
               pitch_in = PVW'(pitch_raw);
            end
         end
         default: begin
            width_in = width_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(RST_W);
         height_ff <= DIM_W'(RESET_HEIGHT);
         pitch_ff  <= PVW'(RST_P);
      end else if (csr_fire) begin
         width_ff  <= width_in;
         height_ff <= height_in;
         pitch_ff  <= pitch_in;
      end
   end

   dgt_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_PITCH (MAX_PITCH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_alpha       (req_alpha),
      .req_frame_start (req_frame_start),
      .cfg_width       (width_ff),
      .cfg_height      (height_ff),
      .cfg_pitch       (pitch_ff),
      .quad_valid      (fq_valid),
      .quad_ready      (fq_ready),
      .quad_data       (fq_data)
   );

   dgt_queue #(
      .DATA_W (QUAD_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_pop),
      .pop_data   (qb_data)
   );

   dgt_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .quad_valid  (qb_valid),
      .quad_pop    (qb_pop),
      .quad_data   (qb_data),
      .cfg_width   (width_ff),
      .cfg_height  (height_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_vert_x2 (rsp_vert_x2),
      .rsp_vert_y2 (rsp_vert_y2),
      .rsp_vert_z  (rsp_vert_z),
      .rsp_last    (rsp_last)
   );

endmodule
